// ===== src/udpq_pkg.sv =====
// Shared types, constants and operation codes for the unique-key double-ended priority queue.
package udpq_pkg;

    // Default sizes
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 20;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 20;
    localparam int KEY_FLD_W = 20;
    localparam int COUNT_W   = 9;
    localparam int SUM_W     = 28;

    // Stream widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 88;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;     // register compare flags against the new key
        logic upd_en;     // apply the shift for this item
        logic do_ins;     // open a slot and insert the new entry
        logic do_delmin;  // shift every entry down by one
    } cell_ctrl_t;

endpackage

// ===== src/udpq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, compares and shifts.
module udpq_cell #(
    parameter int INDEX  = 0,
    parameter int KW     = 20,
    parameter int CNT_W  = 9
) (
    input  logic                        aclk,
    input  udpq_pkg::cell_ctrl_t        ctrl,
    input  logic [KW-1:0]               cmp_key,
    input  logic [CNT_W-1:0]            held_count,
    input  logic [KW-1:0]               new_key,
    input  logic [udpq_pkg::VALUE_W-1:0] new_value,
    input  logic                        left_lt,
    input  logic [KW-1:0]               left_key,
    input  logic [udpq_pkg::VALUE_W-1:0] left_value,
    input  logic [KW-1:0]               right_key,
    input  logic [udpq_pkg::VALUE_W-1:0] right_value,
    output logic [KW-1:0]               key_reg,
    output logic [udpq_pkg::VALUE_W-1:0] value_reg,
    output logic                        lt_reg,
    output logic                        eq_reg,
    output logic                        last_reg
);

    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

    logic                         occupied;
    logic [KW-1:0]                key_next;
    logic [udpq_pkg::VALUE_W-1:0] value_next;

    assign occupied = (MY_POS < held_count);

    // Pick the entry this cell holds after the item
    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.upd_en) begin
            if (ctrl.do_ins && !lt_reg) begin
                if (left_lt) begin
                    key_next   = new_key;
                    value_next = new_value;
                end else begin
                    key_next   = left_key;
                    value_next = left_value;
                end
            end else if (ctrl.do_delmin) begin
                key_next   = right_key;
                value_next = right_value;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // Register the compare flags when an item arrives
    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg   <= occupied && (key_reg < cmp_key);
            eq_reg   <= occupied && (key_reg == cmp_key);
            last_reg <= (MY_NEXT == held_count);
        end
    end

endmodule

// ===== src/unique_key_double_ended_pqueue.sv =====
// Top level: sequencer, totals and output register around the sorted cell chain.
//
//  port group | dir | fields (low bit first)
//  s_axis     | in  | operation, entry_value, entry_key
//  m_axis     | out | removed_valid, removed_key, inserted, dropped_full,
//             |     | entry_count, total_value, total_key
//
// For each item, the accept edge registers the compare flags in every
// cell; in ST_UPD, once the output register is free, the chain shifts and the
// output register loads. No new item is accepted until the previous one is
// applied; a stalled output holds the update until the waiting item is taken.
// Reset (aresetn low, synchronous) empties the queue and clears the totals;
// cell contents are not cleared, slots at or above the count are never read.
module unique_key_double_ended_pqueue #(
    parameter int CAPACITY = udpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = udpq_pkg::KEY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] operation, [21:2] entry_value, [41:22] entry_key, [47:42] zero
    input  logic [udpq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] removed_valid, [20:1] removed_key, [21] inserted, [22] dropped_full,
    // [31:23] entry_count, [59:32] total_value, [87:60] total_key
    output logic [udpq_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int KW    = (KEY_BITS < udpq_pkg::KEY_FLD_W) ? KEY_BITS : udpq_pkg::KEY_FLD_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > udpq_pkg::COUNT_W) ? CNT_W : udpq_pkg::COUNT_W;
    localparam int VW    = udpq_pkg::VALUE_W;
    localparam int SW    = udpq_pkg::SUM_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UPD  = 3'b010,
        ST_SPARE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Input field split
    udpq_pkg::op_t in_op;
    logic [VW-1:0] in_value;
    logic [KW-1:0] in_key;
    assign in_op    = udpq_pkg::op_t'(s_tdata[1:0]);
    assign in_value = s_tdata[21:2];
    assign in_key   = s_tdata[22 +: KW];

    // Item registers
    udpq_pkg::op_t op_reg;
    logic [VW-1:0] value_reg;
    logic [KW-1:0] key_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]    ksum_reg, ksum_next;
    logic [SW-1:0]    vsum_reg, vsum_next;

    logic                        out_valid_reg;
    logic [udpq_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic s_fire, out_free, apply;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign apply    = (state_reg == ST_UPD) && out_free;

    // Chain wiring
    logic [KW-1:0] cell_key   [CAPACITY];
    logic [VW-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_lt, cell_eq, cell_last;

    logic present, full, is_del, ins_ok, drop_ok, del_ok;
    udpq_pkg::cell_ctrl_t ctrl;

    assign present = |cell_eq;
    assign full    = (count_reg == FULL_COUNT);
    assign is_del  = (op_reg == udpq_pkg::OP_DEL_MAX) || (op_reg == udpq_pkg::OP_DEL_MIN);
    assign ins_ok  = (op_reg == udpq_pkg::OP_INSERT) && !present && !full;
    assign drop_ok = (op_reg == udpq_pkg::OP_INSERT) && !present && full;
    assign del_ok  = is_del && (count_reg != '0);

    assign ctrl.cmp_en    = s_fire;
    assign ctrl.upd_en    = apply;
    assign ctrl.do_ins    = ins_ok;
    assign ctrl.do_delmin = del_ok && (op_reg == udpq_pkg::OP_DEL_MIN);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic          l_lt;
            logic [KW-1:0] l_key, r_key;
            logic [VW-1:0] l_value, r_value;
            if (gi == 0) begin : g_first
                assign l_lt    = 1'b1;
                assign l_key   = '0;
                assign l_value = '0;
            end else begin : g_mid
                assign l_lt    = cell_lt[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_value = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_end
                assign r_key   = cell_key[gi];
                assign r_value = cell_value[gi];
            end else begin : g_inner
                assign r_key   = cell_key[gi+1];
                assign r_value = cell_value[gi+1];
            end
            udpq_cell #(
                .INDEX (gi),
                .KW    (KW),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cmp_key     (in_key),
                .held_count  (count_reg),
                .new_key     (key_reg),
                .new_value   (value_reg),
                .left_lt     (l_lt),
                .left_key    (l_key),
                .left_value  (l_value),
                .right_key   (r_key),
                .right_value (r_value),
                .key_reg     (cell_key[gi]),
                .value_reg   (cell_value[gi]),
                .lt_reg      (cell_lt[gi]),
                .eq_reg      (cell_eq[gi]),
                .last_reg    (cell_last[gi])
            );
        end
    endgenerate

    // Gather the top entry through an and-or tree on the last-cell flags
    logic [KW-1:0] max_key;
    logic [VW-1:0] max_value;
    always_comb begin
        max_key   = '0;
        max_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            max_key   = max_key | (cell_key[i] & {KW{cell_last[i]}});
            max_value = max_value | (cell_value[i] & {VW{cell_last[i]}});
        end
    end

    logic [KW-1:0] rem_key;
    logic [VW-1:0] rem_value;
    assign rem_key   = (op_reg == udpq_pkg::OP_DEL_MAX) ? max_key : cell_key[0];
    assign rem_value = (op_reg == udpq_pkg::OP_DEL_MAX) ? max_value : cell_value[0];

    // Advance count and totals
    always_comb begin
        count_next = count_reg;
        ksum_next  = ksum_reg;
        vsum_next  = vsum_reg;
        if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
            ksum_next  = ksum_reg + SW'(key_reg);
            vsum_next  = vsum_reg + SW'(value_reg);
        end else if (del_ok) begin
            count_next = count_reg - CNT_W'(1);
            ksum_next  = ksum_reg - SW'(rem_key);
            vsum_next  = vsum_reg - SW'(rem_value);
        end
    end

    // Pack the result item
    logic [CW-1:0]                  count_ext;
    logic [udpq_pkg::KEY_FLD_W-1:0] rem_key_fld;
    assign count_ext   = CW'(count_next);
    assign rem_key_fld = del_ok ? udpq_pkg::KEY_FLD_W'(rem_key) : '0;
    assign out_data_next = {ksum_next,
                            vsum_next,
                            count_ext[udpq_pkg::COUNT_W-1:0],
                            drop_ok,
                            ins_ok,
                            rem_key_fld,
                            del_ok};

    // Sequence the two steps of an item
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ksum_reg      <= '0;
            vsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply) begin
                count_reg     <= count_next;
                ksum_reg      <= ksum_next;
                vsum_reg      <= vsum_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= in_op;
            value_reg <= in_value;
            key_reg   <= in_key;
        end
        if (apply) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sim/tb_unique_key_double_ended_pqueue.sv =====
// Testbench for the unique-key double-ended priority queue: shadow scoreboard and drivers.
module tb_unique_key_double_ended_pqueue;

    localparam int PQ_CAPACITY  = udpq_pkg::CAPACITY_DEF;
    localparam int PQ_KEY_BITS  = udpq_pkg::KEY_BITS_DEF;
    localparam int OP_W         = udpq_pkg::OP_W;
    localparam int VALUE_W      = udpq_pkg::VALUE_W;
    localparam int KEY_FLD_W    = udpq_pkg::KEY_FLD_W;
    localparam int COUNT_W      = udpq_pkg::COUNT_W;
    localparam int SUM_W        = udpq_pkg::SUM_W;
    localparam int S_DATA_W     = udpq_pkg::S_DATA_W;
    localparam int M_DATA_W     = udpq_pkg::M_DATA_W;
    localparam int PAD_W        = S_DATA_W - OP_W - VALUE_W - KEY_FLD_W;
    localparam int ITEM_TARGET  = 1350;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 200;

    // Input item, zero pad at the top, then entry_key, operation in the low bits
    typedef struct packed {
        logic [PAD_W-1:0]     pad;
        logic [KEY_FLD_W-1:0] entry_key;
        logic [VALUE_W-1:0]   entry_value;
        udpq_pkg::op_t        operation;
    } pq_cmd_t;

    // Result item, total_key at the top, removed_valid in bit 0
    typedef struct packed {
        logic [SUM_W-1:0]     total_key;
        logic [SUM_W-1:0]     total_value;
        logic [COUNT_W-1:0]   entry_count;
        logic                 dropped_full;
        logic                 inserted;
        logic [KEY_FLD_W-1:0] removed_key;
        logic                 removed_valid;
    } pq_report_t;

    typedef struct {
        logic [KEY_FLD_W-1:0] key;
        logic [VALUE_W-1:0]   val;
    } held_item_t;

    // Shadow of the queue contents plus the reports it still owes
    class queue_shadow;
        held_item_t       held[$];
        pq_report_t       expected_reports[$];
        logic [SUM_W-1:0] key_sum;
        logic [SUM_W-1:0] value_sum;
        int               errors;
        int               n_checked;
        int               n_full_drop;
        int               n_dup;
        int               n_empty_del;
        int               peak;

        function new();
            key_sum     = '0;
            value_sum   = '0;
            errors      = 0;
            n_checked   = 0;
            n_full_drop = 0;
            n_dup       = 0;
            n_empty_del = 0;
            peak        = 0;
        endfunction

        // Apply one accepted item to the shadow and queue the report it causes
        function void apply_op(pq_cmd_t cmd);
            pq_report_t r;
            held_item_t e;
            int         pos;
            r = '0;
            case (cmd.operation)
                udpq_pkg::OP_INSERT: begin
                    pos = 0;
                    while (pos < held.size() && held[pos].key < cmd.entry_key)
                        pos++;
                    if (pos < held.size() && held[pos].key == cmd.entry_key) begin
                        n_dup++;
                    end else if (held.size() >= PQ_CAPACITY) begin
                        r.dropped_full = 1'b1;
                        n_full_drop++;
                    end else begin
                        e.key = cmd.entry_key;
                        e.val = cmd.entry_value;
                        held.insert(pos, e);
                        key_sum   = key_sum + SUM_W'(e.key);
                        value_sum = value_sum + SUM_W'(e.val);
                        r.inserted = 1'b1;
                    end
                end
                udpq_pkg::OP_DEL_MAX, udpq_pkg::OP_DEL_MIN: begin
                    if (held.size() > 0) begin
                        if (cmd.operation == udpq_pkg::OP_DEL_MAX)
                            e = held.pop_back();
                        else
                            e = held.pop_front();
                        key_sum   = key_sum - SUM_W'(e.key);
                        value_sum = value_sum - SUM_W'(e.val);
                        r.removed_valid = 1'b1;
                        r.removed_key   = e.key;
                    end else begin
                        n_empty_del++;
                    end
                end
                default: ;
            endcase
            if (held.size() > peak)
                peak = held.size();
            r.entry_count = COUNT_W'(held.size());
            r.total_value = value_sum;
            r.total_key   = key_sum;
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [SUM_W-1:0] want_v,
                                  logic [SUM_W-1:0] got_v);
            if (want_v !== got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        // Compare one accepted result with the oldest owed report
        function void check_result(logic [M_DATA_W-1:0] raw);
            pq_report_t got;
            pq_report_t want;
            got = raw;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, raw);
                return;
            end
            want = expected_reports.pop_front();
            n_checked++;
            check_field("removed_valid", SUM_W'(want.removed_valid), SUM_W'(got.removed_valid));
            check_field("removed_key",   SUM_W'(want.removed_key),   SUM_W'(got.removed_key));
            check_field("inserted",      SUM_W'(want.inserted),      SUM_W'(got.inserted));
            check_field("dropped_full",  SUM_W'(want.dropped_full),  SUM_W'(got.dropped_full));
            check_field("entry_count",   SUM_W'(want.entry_count),   SUM_W'(got.entry_count));
            check_field("total_value",   want.total_value,           got.total_value);
            check_field("total_key",     want.total_key,             got.total_key);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    queue_shadow board;
    int          n_sent  = 0;
    int          n_holds = 0;

    unique_key_double_ended_pqueue #(
        .CAPACITY (PQ_CAPACITY),
        .KEY_BITS (PQ_KEY_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    // Half the keys from a small pool for duplicates, the rest full-range or boundary keys
    function automatic logic [KEY_FLD_W-1:0] pick_key();
        logic [KEY_FLD_W-1:0] k;
        case ($urandom_range(0, 5))
            0, 1, 2: k = KEY_FLD_W'($urandom_range(0, 31));
            3, 4:    k = KEY_FLD_W'($urandom);
            default: begin
                if ($urandom_range(0, 1)) begin
                    k = '1;
                    k = k - KEY_FLD_W'($urandom_range(0, 2));
                end else begin
                    k = KEY_FLD_W'($urandom_range(0, 2));
                end
            end
        endcase
        return k;
    endfunction

    function automatic logic [KEY_FLD_W-1:0] held_key();
        return board.held[$urandom_range(0, board.held.size() - 1)].key;
    endfunction

    // Offer one item, hold it until accepted, then idle for a drawn gap
    task automatic send_cmd(udpq_pkg::op_t op, logic [VALUE_W-1:0] val,
                            logic [KEY_FLD_W-1:0] key);
        pq_cmd_t cmd;
        int      gap;
        cmd = '{pad: '0, entry_key: key, entry_value: val, operation: op};
        s_tdata  <= cmd;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.apply_op(cmd);
        n_sent++;
        gap = draw_wait(((n_sent / 40) % 4) == 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_noise_op(udpq_pkg::op_t op);
        send_cmd(op, VALUE_W'($urandom), KEY_FLD_W'($urandom));
    endtask

    // Extremes, every operation, duplicates and deletes on an empty queue
    task automatic run_directed();
        send_cmd(udpq_pkg::OP_DEL_MAX, '0, '0);
        send_cmd(udpq_pkg::OP_DEL_MIN, '1, '1);
        send_cmd(udpq_pkg::OP_QUERY, '1, '1);
        send_cmd(udpq_pkg::OP_INSERT, '1, '0);
        send_cmd(udpq_pkg::OP_INSERT, '0, '1);
        send_cmd(udpq_pkg::OP_INSERT, 20'hAAAAA, 20'h55555);
        send_cmd(udpq_pkg::OP_INSERT, 20'h55555, 20'hAAAAA);
        send_cmd(udpq_pkg::OP_INSERT, 20'h12345, '1);
        send_cmd(udpq_pkg::OP_INSERT, '1, '0);
        send_cmd(udpq_pkg::OP_QUERY, '0, '0);
        send_cmd(udpq_pkg::OP_DEL_MAX, '1, '1);
        send_cmd(udpq_pkg::OP_DEL_MIN, '0, '0);
        send_cmd(udpq_pkg::OP_INSERT, 20'h00001, 20'h80000);
        send_cmd(udpq_pkg::OP_DEL_MAX, 20'h55555, 20'hAAAAA);
        send_cmd(udpq_pkg::OP_DEL_MIN, 20'hAAAAA, 20'h55555);
        send_cmd(udpq_pkg::OP_DEL_MAX, '0, '0);
        send_cmd(udpq_pkg::OP_DEL_MIN, '0, '0);
        send_cmd(udpq_pkg::OP_DEL_MAX, '0, '0);
        send_cmd(udpq_pkg::OP_QUERY, 20'h5A5A5, 20'hA5A5A);
    endtask

    // Random operations over a mostly small key space
    task automatic run_mixed(int count);
        int n;
        n = 0;
        while (n < count && n_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_cmd(udpq_pkg::OP_INSERT, VALUE_W'($urandom), pick_key());
                4, 5:       send_noise_op(udpq_pkg::OP_DEL_MAX);
                6, 7:       send_noise_op(udpq_pkg::OP_DEL_MIN);
                8:          send_noise_op(udpq_pkg::OP_QUERY);
                default: begin
                    if (board.held.size() > 0)
                        send_cmd(udpq_pkg::OP_INSERT, VALUE_W'($urandom), held_key());
                    else
                        send_noise_op(udpq_pkg::OP_QUERY);
                end
            endcase
            n++;
        end
    endtask

    // Fill to capacity, then push new and duplicate keys against the full store
    task automatic run_fill();
        while (board.held.size() < PQ_CAPACITY && n_sent < ITEM_TARGET)
            send_cmd(udpq_pkg::OP_INSERT, VALUE_W'($urandom), KEY_FLD_W'($urandom));
        repeat (24) begin
            if (n_sent >= ITEM_TARGET)
                break;
            if ($urandom_range(0, 1) && board.held.size() > 0)
                send_cmd(udpq_pkg::OP_INSERT, VALUE_W'($urandom), held_key());
            else
                send_cmd(udpq_pkg::OP_INSERT, VALUE_W'($urandom), KEY_FLD_W'($urandom));
        end
    endtask

    // Drain from both ends, then poke the empty queue
    task automatic run_drain();
        while (board.held.size() > 0 && n_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1))
                send_noise_op(udpq_pkg::OP_DEL_MAX);
            else
                send_noise_op(udpq_pkg::OP_DEL_MIN);
        end
        send_noise_op(udpq_pkg::OP_DEL_MAX);
        send_noise_op(udpq_pkg::OP_DEL_MIN);
        send_noise_op(udpq_pkg::OP_QUERY);
    endtask

    // Result side: check each item, stall at random, hold off long twice
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                if (board.n_checked == 300 || board.n_checked == 1000) begin
                    stall = HOLD_CYCLES;
                    n_holds++;
                end else begin
                    stall = draw_wait(((board.n_checked / 50) % 4) == 3);
                end
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // End the run when no item moves on either side for too long
    initial begin
        int idle;
        idle = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Reset, stimulus, drain and verdict
    initial begin
        int phase;
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            case (phase % 4)
                0, 2:    run_mixed(150);
                1:       run_fill();
                default: run_drain();
            endcase
            phase++;
        end
        s_tvalid <= 1'b0;
        while (board.expected_reports.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("Sent %0d items, checked %0d results, peak occupancy %0d of %0d.",
                 n_sent, board.n_checked, board.peak, PQ_CAPACITY);
        $display("Full-store drops %0d, duplicate inserts %0d, empty deletes %0d, long holds %0d.",
                 board.n_full_drop, board.n_dup, board.n_empty_del, n_holds);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/udpq_pkg.sv
src/udpq_cell.sv
src/unique_key_double_ended_pqueue.sv
sim/tb_unique_key_double_ended_pqueue.sv
